>>> src/vmm_pkg.sv
// Shared types and constants for the video memory map.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package vmm_pkg;

  // Access codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register index (paddr bit 2 selects among 32-bit registers)
  localparam logic REG_MIRRORING = 1'b0;

  // Store geometry
  localparam int PAT_DEPTH  = 8192;
  localparam int NT_SIZE    = 960;
  localparam int NAME_DEPTH = 2 * NT_SIZE;
  localparam int ATTR_DEPTH = 256;
  localparam int PAL_DEPTH  = 32;

  localparam int NAME_AW = $clog2(NAME_DEPTH);
  localparam int ATTR_AW = $clog2(ATTR_DEPTH);
  localparam int PAL_AW  = $clog2(PAL_DEPTH);

  localparam logic [NAME_AW-1:0] NT_BASE_B  = NAME_AW'(NT_SIZE);
  localparam logic [NAME_AW-1:0] CLEAR_LAST = NAME_AW'(NAME_DEPTH - 1);

  typedef enum logic [1:0] {
    REGION_PATTERN,
    REGION_NAME,
    REGION_ATTR,
    REGION_PALETTE
  } region_t;

  // Sideband carried alongside the RAM read
  typedef struct packed {
    logic       is_write;
    region_t    region;
    logic [7:0] pal_byte;
  } stage_t;

endpackage

`default_nettype wire

>>> src/vmm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependencies.
`default_nettype none

module vmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while not enabled
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/video_memory_map_with_mirroring.sv
// Video bus memory map with name-table mirroring: top level.
// Depends on vmm_pkg and vmm_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one access item: opcode
//   (read or write), 14-bit address and write_data. Output channel
//   (out_valid / out_stall) returns one item per access: read_data, which
//   is zero for writes.
//   The RAM read and sideband are registered at acceptance, and the result
//   register loads from them, setting out_valid, when it is empty or being
//   taken. One item is accepted every cycle while in_stall is low; the
//   stores are separate RAMs with one read and one write port each, so
//   back-to-back accesses never contend. When the receiver stalls, the
//   result register holds and the read stage holds behind it (the RAMs
//   keep their read data); in_stall rises when both are full and the
//   output is stalled, and throughout the clearing pass.
//   After reset, a clearing pass zeroes the name buffers and attribute
//   tables, one entry per cycle, with in_stall high throughout. The
//   pattern store is not cleared and must be written before it is read.
//   Palette entries are flip-flops and clear at once.
//   mirroring_mode sits at APB byte address 0 (bit 0); write it only
//   while no access is in flight.
`default_nettype none

module video_memory_map_with_mirroring (
  input  wire logic        clk,
  input  wire logic        rst,
  // access channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [13:0] address,
  input  wire logic [7:0]  write_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  read_data,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import vmm_pkg::*;

  // Configuration
  logic mirroring_mode;
  logic cfg_write;

  // Clearing pass
  logic               clearing;
  logic [NAME_AW-1:0] clr_cnt;

  // Handshake and stage control
  logic   in_accept;
  logic   s1_valid;
  logic   s1_move;
  stage_t s1;
  stage_t s1_next;

  // Address decode
  region_t            region;
  logic               is_write;
  logic [1:0]         table_sel;
  logic [9:0]         offset;
  logic               buf_sel;
  logic [NAME_AW-1:0] name_addr;
  logic [ATTR_AW-1:0] attr_addr;
  logic [PAL_AW-1:0]  pal_index;
  logic               transparent;

  // Store ports
  logic               pat_we;
  logic               name_we;
  logic [NAME_AW-1:0] name_waddr;
  logic [7:0]         name_wdata;
  logic               attr_we;
  logic [ATTR_AW-1:0] attr_waddr;
  logic [7:0]         attr_wdata;
  logic [7:0]         pat_rdata;
  logic [7:0]         name_rdata;
  logic [7:0]         attr_rdata;
  logic [7:0]         palette [PAL_DEPTH];
  logic [7:0]         result;

  // ---------------------------------------------------------------------
  // APB register
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring_mode <= 1'b0;
    end else if (cfg_write && paddr[2] == REG_MIRRORING) begin
      mirroring_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_MIRRORING) ? {31'b0, mirroring_mode} : 32'b0;

  // ---------------------------------------------------------------------
  // Clearing pass over the name buffers and attribute tables
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLEAR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: the read stage advances when the result register is empty
  // or being taken; a new item enters when the read stage frees up and no clearing runs.
  // ---------------------------------------------------------------------
  assign s1_move   = !out_valid || !out_stall;
  assign in_stall  = clearing || (s1_valid && !s1_move);
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Address decode. The 0x3000 mirror only touches bit 12, so table and
  // offset come straight from bits 11:0.
  // ---------------------------------------------------------------------
  assign is_write  = (opcode == OP_WRITE);
  assign table_sel = address[11:10];
  assign offset    = address[9:0];

  always_comb begin
    if (!address[13]) begin
      region = REGION_PATTERN;
    end else if (address[13:8] == 6'h3F) begin
      region = REGION_PALETTE;
    end else if (offset[9:6] == 4'hF) begin
      // offsets 0x3C0..0x3FF are attribute bytes
      region = REGION_ATTR;
    end else begin
      region = REGION_NAME;
    end
  end

  // horizontal: tables 0,1 on buffer A; vertical: tables 0,2 on buffer A
  assign buf_sel   = mirroring_mode ? table_sel[0] : table_sel[1];
  assign name_addr = NAME_AW'(offset) + (buf_sel ? NT_BASE_B : '0);
  assign attr_addr = {table_sel, offset[5:0]};

  // every fourth palette address from 0x3F04 reads entry 0
  assign transparent = (address[7:2] != 6'b0) && (address[1:0] == 2'b00);
  assign pal_index   = address[PAL_AW-1:0];

  // ---------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------
  assign pat_we = in_accept && is_write && region == REGION_PATTERN;

  vmm_ram #(
    .WIDTH (8),
    .DEPTH (PAT_DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (address[12:0]),
    .wdata (write_data),
    .re    (in_accept),
    .raddr (address[12:0]),
    .rdata (pat_rdata)
  );

  // clearing pass borrows the write ports
  assign name_we    = clearing || (in_accept && is_write && region == REGION_NAME);
  assign name_waddr = clearing ? clr_cnt : name_addr;
  assign name_wdata = clearing ? 8'h00 : write_data;

  vmm_ram #(
    .WIDTH (8),
    .DEPTH (NAME_DEPTH)
  ) u_name (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_wdata),
    .re    (in_accept),
    .raddr (name_addr),
    .rdata (name_rdata)
  );

  assign attr_we = (clearing && clr_cnt < NAME_AW'(ATTR_DEPTH))
                || (in_accept && is_write && region == REGION_ATTR);
  assign attr_waddr = clearing ? clr_cnt[ATTR_AW-1:0] : attr_addr;
  assign attr_wdata = clearing ? 8'h00 : write_data;

  vmm_ram #(
    .WIDTH (8),
    .DEPTH (ATTR_DEPTH)
  ) u_attr (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .re    (in_accept),
    .raddr (attr_addr),
    .rdata (attr_rdata)
  );

  // Palette in flip-flops; writes always go to the masked entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        palette[i] <= 8'h00;
      end
    end else if (in_accept && is_write && region == REGION_PALETTE) begin
      palette[pal_index] <= write_data;
    end
  end

  // ---------------------------------------------------------------------
  // Read stage: sideband registered alongside the RAM reads
  // ---------------------------------------------------------------------
  always_comb begin
    s1_next.is_write = is_write;
    s1_next.region   = region;
    s1_next.pal_byte = transparent ? palette[0] : palette[pal_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_comb begin
    case (s1.region)
      REGION_PATTERN: result = pat_rdata;
      REGION_NAME:    result = name_rdata;
      REGION_ATTR:    result = attr_rdata;
      default:        result = s1.pal_byte;
    endcase
    // writes return zero
    if (s1.is_write) begin
      result = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      read_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> src/vmm_checker.sv
// Port-level checks for the video memory map, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module vmm_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] read_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("result changed while stalled");

  // clearing pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

  // a rising out_valid must match an earlier accepted item
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching accepted item");

endmodule

bind video_memory_map_with_mirroring vmm_port_checks u_vmm_checker (.*);

`default_nettype wire

>>> tb/vmm_checker.sv
// Checker for the video memory map: keeps a shadow of every store and the mirroring mode.
// Predicts read_data for each access and compares results in order.
// Depends on vmm_pkg. Watches the block's ports only.
module vmm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [13:0] address,
  input  logic [7:0]  write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  import vmm_pkg::*;

  localparam logic [2:0] MIRROR_ADDR = {REG_MIRRORING, 2'b00};

  typedef struct packed {
    logic [13:0] addr;
    logic [7:0]  data;
  } pending_read_t;

  logic [7:0]    pattern_mem [PAT_DEPTH];
  logic [7:0]    name_mem    [NAME_DEPTH];
  logic [7:0]    attr_mem    [ATTR_DEPTH];
  logic [7:0]    pal_mem     [PAL_DEPTH];
  logic          mirror_vertical;
  pending_read_t read_queue [$];
  pending_read_t head;
  int            fail_count;

  // Resolve the access to a shadow cell, update it on a write, return the byte read.
  function automatic logic [7:0] apply_access(input logic op, input logic [13:0] addr,
                                              input logic [7:0] wdata);
    logic [13:0] folded;
    logic [1:0]  nt_sel;
    logic [9:0]  offset;
    logic        bank;
    region_t     region;
    int          idx;
    logic [7:0]  rdata;
    folded = (addr >= 14'h3000 && addr < 14'h3F00) ? addr - 14'h1000 : addr;
    nt_sel = folded[11:10];
    offset = folded[9:0];
    bank   = mirror_vertical ? nt_sel[0] : nt_sel[1];
    if (addr < 14'h2000) begin
      region = REGION_PATTERN;
      idx    = int'(addr[12:0]);
    end else if (addr >= 14'h3F00) begin
      region = REGION_PALETTE;
      idx    = int'(addr[4:0]);
    end else if (offset >= 10'h3C0) begin
      region = REGION_ATTR;
      idx    = int'(nt_sel) * 64 + int'(offset[5:0]);
    end else begin
      region = REGION_NAME;
      idx    = int'(bank) * NT_SIZE + int'(offset);
    end
    rdata = 8'h00;
    if (op == OP_WRITE) begin
      case (region)
        REGION_PATTERN: pattern_mem[idx] = wdata;
        REGION_NAME:    name_mem[idx]    = wdata;
        REGION_ATTR:    attr_mem[idx]    = wdata;
        default:        pal_mem[idx]     = wdata;
      endcase
    end else if (addr >= 14'h3F04 && addr[1:0] == 2'b00) begin
      // transparent palette slots all read back entry 0
      rdata = pal_mem[0];
    end else begin
      case (region)
        REGION_PATTERN: rdata = pattern_mem[idx];
        REGION_NAME:    rdata = name_mem[idx];
        REGION_ATTR:    rdata = attr_mem[idx];
        default:        rdata = pal_mem[idx];
      endcase
    end
    return rdata;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (name_mem[i]) name_mem[i] = 8'h00;
      foreach (attr_mem[i]) attr_mem[i] = 8'h00;
      foreach (pal_mem[i]) pal_mem[i] = 8'h00;
      mirror_vertical = 1'b0;
      read_queue.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pready && paddr == MIRROR_ADDR) begin
        if (pwrite) begin
          mirror_vertical = pwdata[0];
        end else if (prdata[0] !== mirror_vertical) begin
          note_failure($sformatf("mirroring_mode readback: expected %0d, got %0d",
                                 mirror_vertical, prdata[0]));
        end
      end
      // retire first so a result and a new access on one edge stay in order
      if (out_valid && !out_stall) begin
        if (read_queue.size() == 0) begin
          note_failure($sformatf("result %02h with no access outstanding", read_data));
        end else begin
          head = read_queue.pop_front();
          if (read_data !== head.data) begin
            note_failure($sformatf("address %04h: read_data expected %02h, got %02h",
                                   head.addr, head.data, read_data));
          end
        end
      end
      if (in_valid && !in_stall) begin
        head.addr = address;
        head.data = apply_access(opcode, address, write_data);
        read_queue.push_back(head);
      end
    end
    mismatches  <= fail_count;
    outstanding <= read_queue.size();
  end

endmodule

>>> tb/tb_video_memory_map_with_mirroring.sv
// Top of the video memory map testbench: clock, reset, access stimulus, result
// stalls, APB setup of the mirroring mode, watchdog and verdict.
// Depends on vmm_pkg, the block and vmm_checker.
module tb_video_memory_map_with_mirroring;
  import vmm_pkg::*;

  localparam int         PHASE_ITEMS    = 540;
  localparam int         HOLD_LEN       = 300;   // long receiver hold-off, in cycles
  localparam int         DRAIN_CYCLES   = 4;     // extra wait after the last result, as a margin
  localparam int         WATCHDOG_LIMIT = 8000;  // must outlast the clearing pass
  localparam logic [2:0] MIRROR_ADDR    = {REG_MIRRORING, 2'b00};

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        opcode     = OP_READ;
  logic [13:0] address    = '0;
  logic [7:0]  write_data = '0;
  logic        out_stall  = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  read_data;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  // Idle rates in percent, set per phase by the stimulus
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Hold-off request: the stimulus toggles the token, the receiver counts the stretch
  bit hold_token = 1'b0;
  bit hold_seen  = 1'b0;
  int hold_left  = 0;

  int idle_cycles = 0;

  // Pattern entries written so far; reads only ever target these
  bit          pat_written [PAT_DEPTH];
  logic [12:0] pat_list [$];

  video_memory_map_with_mirroring i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  vmm_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // Result side: honor a pending hold-off first, otherwise stall at the phase rate
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Write the mirroring mode, then read it back in a second transfer.
  task automatic cfg_write(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIRROR_ADDR;
    pwdata  <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // back-to-back read: drop to setup with psel held
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one access; insert idle cycles at the phase rate, hold the payload until taken.
  task automatic put_access(input logic op, input logic [13:0] addr, input logic [7:0] data);
    if (op == OP_WRITE && addr < 14'h2000 && !pat_written[addr[12:0]]) begin
      pat_written[addr[12:0]] = 1'b1;
      pat_list.push_back(addr[12:0]);
    end
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    write_data <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every access has come back, plus DRAIN_CYCLES.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random access. Bias toward small hot sets so reads hit earlier writes,
  // and across mirrors, while a share of fully random addresses covers every bit.
  task automatic rand_access();
    logic        op;
    logic [7:0]  data;
    int          pick;
    int          nt;
    int          off;
    int          a;
    op   = $urandom_range(1, 0) ? OP_WRITE : OP_READ;
    data = 8'($urandom_range(255, 0));
    pick = $urandom_range(99, 0);
    if (pick < 25) begin
      if (op == OP_READ && pat_list.size() != 0) begin
        a = pat_list[$urandom_range(pat_list.size() - 1, 0)];
      end else begin
        a = $urandom_range(1, 0) ? $urandom_range(255, 0) : $urandom_range(8191, 0);
      end
    end else if (pick < 75) begin
      nt = $urandom_range(3, 0);
      if (pick < 58) begin
        off = $urandom_range(1, 0) ? $urandom_range(15, 0) : $urandom_range(959, 0);
      end else begin
        off = 'h3C0 + $urandom_range(63, 0);
      end
      a = 'h2000 + nt * 'h400 + off;
      // take the upper mirror where it does not run into the palette
      if ($urandom_range(3, 0) == 0 && a + 'h1000 < 'h3F00) a = a + 'h1000;
    end else if (pick < 90) begin
      a = 'h3F00 + $urandom_range(255, 0);
    end else begin
      a = $urandom_range(16383, 0);
    end
    // never read a pattern entry that has not been written: turn it into a write
    if (a < 'h2000 && op == OP_READ && !pat_written[a]) op = OP_WRITE;
    put_access(op, 14'(a), data);
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) rand_access();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Vertical mirroring for the directed part: tables 0 and 2 share a buffer.
    cfg_write(1'b1);

    // Pattern store extremes, then read them back
    put_access(OP_WRITE, 14'h0000, 8'hFF);
    put_access(OP_WRITE, 14'h1FFF, 8'hA5);
    put_access(OP_READ,  14'h0000, 8'h00);
    put_access(OP_READ,  14'h1FFF, 8'h00);
    // Name tables: first and last name bytes, seen through the mirrors
    put_access(OP_WRITE, 14'h2000, 8'h5A);
    put_access(OP_WRITE, 14'h2FBF, 8'hC3);
    put_access(OP_READ,  14'h2800, 8'h00);
    put_access(OP_READ,  14'h27BF, 8'h00);
    put_access(OP_READ,  14'h3000, 8'h00);
    // Attribute tables stay separate per logical table; then a name byte via the top mirror
    put_access(OP_WRITE, 14'h23C0, 8'h81);
    put_access(OP_WRITE, 14'h2FFF, 8'h7E);
    put_access(OP_READ,  14'h27C0, 8'h00);
    put_access(OP_READ,  14'h2FFF, 8'h00);
    put_access(OP_READ,  14'h3EFF, 8'h00);
    // Palette: transparent slots read entry 0 but write their own entry
    put_access(OP_WRITE, 14'h3F00, 8'h0F);
    put_access(OP_WRITE, 14'h3F04, 8'h2C);
    put_access(OP_READ,  14'h3F04, 8'h00);
    put_access(OP_READ,  14'h3F24, 8'h00);
    put_access(OP_WRITE, 14'h3F1F, 8'h3F);
    put_access(OP_READ,  14'h3FFF, 8'h00);
    put_access(OP_READ,  14'h3FFC, 8'h00);
    put_access(OP_READ,  14'h3F20, 8'h00);
    put_access(OP_WRITE, 14'h3F14, 8'h22);
    put_access(OP_READ,  14'h3F14, 8'h00);
    // read with write_data set: the byte must be ignored
    put_access(OP_READ,  14'h2000, 8'hFF);
    drain();

    // Horizontal mode: sender idles lightly, receiver heavily. Open with a long
    // hold-off so the pipeline fills and backs up into in_stall.
    cfg_write(1'b0);
    send_idle_pct = 28;
    stall_pct    <= 56;
    hold_token   <= ~hold_token;
    run_random(PHASE_ITEMS);
    drain();

    // Vertical mode with the rates swapped
    cfg_write(1'b1);
    send_idle_pct = 56;
    stall_pct    <= 28;
    run_random(PHASE_ITEMS);
    drain();

    // Horizontal again at full rate; another hold-off, and a pause halfway
    cfg_write(1'b0);
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_token   <= ~hold_token;
    run_random(PHASE_ITEMS / 2);
    drain();
    run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> video_memory_map_with_mirroring.f
src/vmm_pkg.sv
src/vmm_ram.sv
src/video_memory_map_with_mirroring.sv
src/vmm_checker.sv
tb/vmm_checker.sv
tb/tb_video_memory_map_with_mirroring.sv
